/* sv/nearest_node_search_2d_unit_defines.svh */
// assertion macros used by the checker file
// no dependencies; the including scope provides clk and rst_n
`ifndef NEAREST_NODE_SEARCH_2D_UNIT_DEFINES_SVH
`define NEAREST_NODE_SEARCH_2D_UNIT_DEFINES_SVH

// same-cycle implication
`define NNS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NNS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/nns_pkg.sv */
// shared constants, codes and types for the nearest node search unit
// no dependencies
`timescale 1ns / 1ps

package nns_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int COORD_BITS = 24;

    localparam int IN_COORD_W = 24;
    localparam int CW         = (COORD_BITS < IN_COORD_W) ? COORD_BITS : IN_COORD_W;
    localparam int IDX_W      = $clog2(MAX_NODES);
    localparam int CNT_W      = $clog2(MAX_NODES + 1);
    localparam int SQ_W       = 2 * CW;
    localparam int DIST_W     = SQ_W + 1;

    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int OUT_IDX_W  = 10;
    localparam int OUT_DIST_W = 49;
    localparam int OUT_CNT_W  = 11;

    localparam logic [OP_W-1:0] OP_APPEND = OP_W'(0);
    localparam logic [OP_W-1:0] OP_QUERY  = OP_W'(1);
    localparam logic [OP_W-1:0] OP_CLEAR  = OP_W'(2);

    localparam logic [STATUS_W-1:0] STAT_OK    = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STAT_EMPTY = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STAT_FULL  = STATUS_W'(2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

endpackage

/* sv/nns_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module nns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/nns_axis_cell.sv */
// one axis cell: absolute difference stage then squaring stage
// depends on nns_pkg
`timescale 1ns / 1ps

module nns_axis_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid_in,
    input  logic signed [nns_pkg::CW-1:0] node_coord,
    input  logic signed [nns_pkg::CW-1:0] query_coord,
    output logic                          valid_out,
    output logic                          busy,
    output logic [nns_pkg::SQ_W-1:0]      sq
);

    import nns_pkg::*;

    logic            v1_reg;
    logic            v2_reg;
    logic [CW-1:0]   mag_reg;
    logic [CW-1:0]   mag_next;
    logic [SQ_W-1:0] sq_reg;
    logic [SQ_W-1:0] sq_next;

    // magnitude below 2^CW, so the wrapped difference is exact
    always_comb
    begin
        if (node_coord >= query_coord)
        begin
            mag_next = $unsigned(node_coord) - $unsigned(query_coord);
        end
        else
        begin
            mag_next = $unsigned(query_coord) - $unsigned(node_coord);
        end
        sq_next = SQ_W'(mag_reg) * SQ_W'(mag_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        sq_reg  <= sq_next;
    end

    assign valid_out = v2_reg;
    assign busy      = v1_reg | v2_reg;
    assign sq        = sq_reg;

endmodule

/* sv/nns_min_cell.sv */
// running minimum cell: sums the axis squares and keeps the earliest least distance
// depends on nns_pkg
`timescale 1ns / 1ps

module nns_min_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear,
    input  logic                        valid_in,
    input  logic [nns_pkg::SQ_W-1:0]    sq_x,
    input  logic [nns_pkg::SQ_W-1:0]    sq_y,
    input  logic [nns_pkg::IDX_W-1:0]   idx_in,
    output logic [nns_pkg::DIST_W-1:0]  best_dist,
    output logic [nns_pkg::IDX_W-1:0]   best_idx
);

    import nns_pkg::*;

    logic              have_reg;
    logic              have_next;
    logic [DIST_W-1:0] sum;
    logic              take;
    logic [DIST_W-1:0] best_dist_reg;
    logic [IDX_W-1:0]  best_idx_reg;

    always_comb
    begin
        sum       = DIST_W'(sq_x) + DIST_W'(sq_y);
        take      = valid_in && (!have_reg || (sum < best_dist_reg));
        have_next = clear ? 1'b0 : (have_reg | valid_in);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_dist_reg <= sum;
            best_idx_reg  <= idx_in;
        end
    end

    assign best_dist = best_dist_reg;
    assign best_idx  = best_idx_reg;

endmodule

/* sv/nearest_node_search_2d_unit.sv */
// top level of the nearest node search unit: node tables, scan control, result register
// depends on nns_pkg, nns_ram, nns_axis_cell, nns_min_cell
//
//   channel   handshake             word
//   input     in_valid / in_stall   operation, point_x, point_y
//   output    out_valid / out_stall nearest_index, nearest_dist_sq, node_count, status
//
// append, clear, unused codes and a query on an empty table go from idle straight to done;
// a query on N stored nodes scans them through the single read port of each table, one node
// per cycle, into the axis cells and the minimum cell, then drains before done
// reset empties the table at once; entries are not cleared
// in_stall is high from acceptance until the word moves into the output register;
// a new word is accepted while a result waits there under out_stall
`timescale 1ns / 1ps

module nearest_node_search_2d_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [nns_pkg::OP_W-1:0]            operation,
    input  logic signed [nns_pkg::IN_COORD_W-1:0] point_x,
    input  logic signed [nns_pkg::IN_COORD_W-1:0] point_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [nns_pkg::OUT_IDX_W-1:0]       nearest_index,
    output logic [nns_pkg::OUT_DIST_W-1:0]      nearest_dist_sq,
    output logic [nns_pkg::OUT_CNT_W-1:0]       node_count,
    output logic [nns_pkg::STATUS_W-1:0]        status
);

    import nns_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  scan_addr_reg;
    logic [CNT_W-1:0]  scan_addr_next;

    logic              accept;
    logic              full;
    logic              scan_issue;
    logic              scan_last;
    logic              pipe_busy;
    logic              out_free;
    logic              done_load;
    logic              drain_end;

    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] qx_reg;
    logic signed [CW-1:0] qy_reg;

    logic [IDX_W-1:0]    res_idx_reg;
    logic [IDX_W-1:0]    res_idx_next;
    logic [DIST_W-1:0]   res_dist_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [STATUS_W-1:0] res_status_next;
    logic [CNT_W-1:0]    res_count_reg;

    logic             rd_valid_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] a_idx_reg;
    logic [IDX_W-1:0] b_idx_reg;

    logic             ram_we;
    logic [CW-1:0]    rdata_x;
    logic [CW-1:0]    rdata_y;

    logic             x_valid;
    logic             y_valid;
    logic             x_busy;
    logic             y_busy;
    logic [SQ_W-1:0]  sq_x;
    logic [SQ_W-1:0]  sq_y;
    logic [DIST_W-1:0] best_dist;
    logic [IDX_W-1:0]  best_idx;

    logic                  out_valid_reg;
    logic [OUT_IDX_W-1:0]  out_idx_reg;
    logic [OUT_DIST_W-1:0] out_dist_reg;
    logic [OUT_CNT_W-1:0]  out_count_reg;
    logic [STATUS_W-1:0]   out_status_reg;

    assign px        = point_x[CW-1:0];
    assign py        = point_y[CW-1:0];
    assign full      = (count_reg == CNT_W'(MAX_NODES));
    assign accept    = in_valid && !in_stall;
    assign scan_last = (CNT_W'(scan_addr_reg + CNT_W'(1)) == count_reg);
    assign pipe_busy = rd_valid_reg | x_busy | y_busy;
    assign out_free  = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_QUERY && count_reg != '0)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall   = 1'b1;
        scan_issue = 1'b0;
        done_load  = 1'b0;
        drain_end  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
            end
            S_SCAN:
            begin
                scan_issue = 1'b1;
            end
            S_DRAIN:
            begin
                drain_end = !pipe_busy;
            end
            S_DONE:
            begin
                done_load = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // table count and immediate results
    always_comb
    begin
        count_next      = count_reg;
        res_idx_next    = '0;
        res_status_next = STAT_OK;
        ram_we          = 1'b0;
        if (accept)
        begin
            case (operation)
                OP_APPEND:
                begin
                    if (full)
                    begin
                        res_status_next = STAT_FULL;
                    end
                    else
                    begin
                        ram_we       = 1'b1;
                        res_idx_next = count_reg[IDX_W-1:0];
                        count_next   = CNT_W'(count_reg + CNT_W'(1));
                    end
                end
                OP_QUERY:
                begin
                    if (count_reg == '0)
                    begin
                        res_status_next = STAT_EMPTY;
                    end
                end
                OP_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    assign scan_addr_next = scan_issue ? CNT_W'(scan_addr_reg + CNT_W'(1)) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_addr_reg <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_addr_reg <= scan_addr_next;
            rd_valid_reg  <= scan_issue;
            out_valid_reg <= done_load || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qx_reg         <= px;
            qy_reg         <= py;
            res_idx_reg    <= res_idx_next;
            res_dist_reg   <= '0;
            res_status_reg <= res_status_next;
            res_count_reg  <= count_next;
        end
        else if (drain_end)
        begin
            res_idx_reg  <= best_idx;
            res_dist_reg <= best_dist;
        end
        rd_idx_reg <= scan_addr_reg[IDX_W-1:0];
        a_idx_reg  <= rd_idx_reg;
        b_idx_reg  <= a_idx_reg;
        if (done_load)
        begin
            out_idx_reg    <= OUT_IDX_W'(res_idx_reg);
            out_dist_reg   <= OUT_DIST_W'(res_dist_reg);
            out_count_reg  <= OUT_CNT_W'(res_count_reg);
            out_status_reg <= res_status_reg;
        end
    end

    nns_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_NODES)
    ) u_ram_x (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (px),
        .re    (scan_issue),
        .raddr (scan_addr_reg[IDX_W-1:0]),
        .rdata (rdata_x)
    );

    nns_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_NODES)
    ) u_ram_y (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (py),
        .re    (scan_issue),
        .raddr (scan_addr_reg[IDX_W-1:0]),
        .rdata (rdata_y)
    );

    nns_axis_cell u_cell_x (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid_in    (rd_valid_reg),
        .node_coord  ($signed(rdata_x)),
        .query_coord (qx_reg),
        .valid_out   (x_valid),
        .busy        (x_busy),
        .sq          (sq_x)
    );

    nns_axis_cell u_cell_y (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid_in    (rd_valid_reg),
        .node_coord  ($signed(rdata_y)),
        .query_coord (qy_reg),
        .valid_out   (y_valid),
        .busy        (y_busy),
        .sq          (sq_y)
    );

    nns_min_cell u_min (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (accept),
        .valid_in  (x_valid & y_valid),
        .sq_x      (sq_x),
        .sq_y      (sq_y),
        .idx_in    (b_idx_reg),
        .best_dist (best_dist),
        .best_idx  (best_idx)
    );

    assign out_valid       = out_valid_reg;
    assign nearest_index   = out_idx_reg;
    assign nearest_dist_sq = out_dist_reg;
    assign node_count      = out_count_reg;
    assign status          = out_status_reg;

endmodule

/* sv/nns_checker.sv */
// port-level checks on the result channel of the nearest node search unit
// depends on nns_pkg and nearest_node_search_2d_unit_defines.svh; bound to the top level
`timescale 1ns / 1ps
`include "nearest_node_search_2d_unit_defines.svh"

module nns_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [nns_pkg::OUT_IDX_W-1:0]   nearest_index,
    input logic [nns_pkg::OUT_DIST_W-1:0]  nearest_dist_sq,
    input logic [nns_pkg::OUT_CNT_W-1:0]   node_count,
    input logic [nns_pkg::STATUS_W-1:0]    status
);

    import nns_pkg::*;

    `NNS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(nearest_index) && $stable(nearest_dist_sq) && $stable(node_count) && $stable(status), "stalled result word changed")
    `NNS_ASSERT_IMPL(a_empty_count, out_valid && status == STAT_EMPTY, node_count == '0, "empty status with nonzero count")
    `NNS_ASSERT_IMPL(a_full_count, out_valid && status == STAT_FULL, node_count == OUT_CNT_W'(MAX_NODES), "full status without a full table")
    `NNS_ASSERT_IMPL(a_err_zero, out_valid && status != STAT_OK, nearest_index == '0 && nearest_dist_sq == '0, "error word carries index or distance")
    `NNS_ASSERT_IMPL(a_none_zero, out_valid && node_count == '0, nearest_index == '0 && nearest_dist_sq == '0, "empty table word carries index or distance")

endmodule

bind nearest_node_search_2d_unit nns_checker u_nns_checker (.*);
